@@ rtl/core/fcull_pkg.sv @@
// Package for the frustum cull test block: plane layout, op codes, verdict codes
// and register indexes. No dependencies; every other file of the block imports it.
package fcull_pkg;

  localparam int NUM_PLANES      = 6;
  localparam int NORM_WIDTH      = 16;
  localparam int Q_SHIFT         = 14;
  localparam int PLANE_WIDTH     = 64;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int COORD_WIDTH_DEF = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_BOUNDS = 2'd0;
  localparam op_t OP_SPHERE = 2'd1;
  localparam op_t OP_CUBE   = 2'd2;
  localparam op_t OP_BOX    = 2'd3;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_OUTSIDE = 2'd0;
  localparam verdict_t VERDICT_PARTIAL = 2'd1;
  localparam verdict_t VERDICT_INSIDE  = 2'd2;

  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LEFT   = 3'd0;
  localparam cfg_idx_t REG_RIGHT  = 3'd1;
  localparam cfg_idx_t REG_TOP    = 3'd2;
  localparam cfg_idx_t REG_BOTTOM = 3'd3;
  localparam cfg_idx_t REG_NEAR   = 3'd4;
  localparam cfg_idx_t REG_FAR    = 3'd5;

  // One plane register: distance in the top half word, normal below it.
  typedef struct packed {
    logic signed [NORM_WIDTH-1:0] d;
    logic signed [NORM_WIDTH-1:0] nz;
    logic signed [NORM_WIDTH-1:0] ny;
    logic signed [NORM_WIDTH-1:0] nx;
  } plane_t;

endpackage

@@ rtl/core/fcull_in_if.sv @@
// Request channel of the frustum cull test block: valid/ready and the bounds payload.
// Depends on fcull_pkg.
interface fcull_in_if import fcull_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  op_t                           op;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] ext_x;
  logic signed [COORD_WIDTH-1:0] ext_y;
  logic signed [COORD_WIDTH-1:0] ext_z;
  logic        [COORD_WIDTH-2:0] radius;

  modport source (output valid, op, pos_x, pos_y, pos_z, ext_x, ext_y, ext_z, radius,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, ext_x, ext_y, ext_z, radius,
                  output ready);
endinterface

@@ rtl/core/fcull_out_if.sv @@
// Result channel of the frustum cull test block: valid/ready and the verdict.
// Depends on fcull_pkg.
interface fcull_out_if import fcull_pkg::*;;
  logic     valid;
  logic     ready;
  verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

@@ rtl/core/frustum_cull_test.sv @@
// Frustum cull test: classifies spheres, cubes and boxes against six planes.
// Depends on fcull_pkg, fcull_in_if and fcull_out_if.
//
//   channel   dir   handshake        payload
//   req_i     in    valid / ready    op, pos_x/y/z, ext_x/y/z, radius
//   rsp_o     out   valid / ready    verdict
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_wdata_i (one plane per index)
//
// One request per cycle while the pipeline is not full; its result comes out
// behind four register stages: corner setup, 36 plane-by-coordinate products,
// per-plane sums, compare. Each stage holds its own valid bit and fills when the
// next one frees, so a stalled result does not block requests until all four
// stages are full. Reset clears the planes and the pipeline; with zero planes
// ops 0, 2 and 3 report outside.
module frustum_cull_test import fcull_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  cfg_idx_t               cfg_idx_i,
  input  logic [PLANE_WIDTH-1:0] cfg_wdata_i,
  fcull_in_if.sink               req_i,
  fcull_out_if.source            rsp_o
);

  localparam int EW = COORD_WIDTH + 1;           // corner coordinate
  localparam int PW = EW + NORM_WIDTH;           // one product
  localparam int SW = COORD_WIDTH + 20;          // extreme-corner plane sum
  localparam int CW = COORD_WIDTH + 21;          // doubled center plane sum
  localparam int RW = COORD_WIDTH - 1;           // radius

  // Plane registers.
  plane_t plane_q [NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) plane_q[p] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT:   plane_q[0] <= plane_t'(cfg_wdata_i);
        REG_RIGHT:  plane_q[1] <= plane_t'(cfg_wdata_i);
        REG_TOP:    plane_q[2] <= plane_t'(cfg_wdata_i);
        REG_BOTTOM: plane_q[3] <= plane_t'(cfg_wdata_i);
        REG_NEAR:   plane_q[4] <= plane_t'(cfg_wdata_i);
        REG_FAR:    plane_q[5] <= plane_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  logic signed [NORM_WIDTH-1:0] nrm [NUM_PLANES][3];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      nrm[p][0] = plane_q[p].nx;
      nrm[p][1] = plane_q[p].ny;
      nrm[p][2] = plane_q[p].nz;
    end
  end

  // Pipeline flow control: a stage loads when it is empty or the next one loads.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_q || rsp_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: the low and high corner coordinate of each axis. For the sphere
  // verdict both equal the center, so the doubled center sum is the same
  // expression for every op.
  logic signed [COORD_WIDTH-1:0] pos [3];
  logic signed [COORD_WIDTH-1:0] ext [3];
  logic signed [EW-1:0]          rad_ext;
  logic signed [EW-1:0]          lo_d [3];
  logic signed [EW-1:0]          hi_d [3];
  logic signed [EW-1:0]          lo1_q [3];
  logic signed [EW-1:0]          hi1_q [3];
  op_t                           op1_q;
  logic [RW-1:0]                 rad1_q;

  always_comb begin
    pos[0]  = req_i.pos_x;
    pos[1]  = req_i.pos_y;
    pos[2]  = req_i.pos_z;
    ext[0]  = req_i.ext_x;
    ext[1]  = req_i.ext_y;
    ext[2]  = req_i.ext_z;
    rad_ext = signed'({2'b00, req_i.radius});
    for (int a = 0; a < 3; a++) begin
      case (req_i.op)
        OP_BOUNDS: begin
          lo_d[a] = EW'(pos[a]) - EW'(ext[a]);
          hi_d[a] = EW'(pos[a]) + EW'(ext[a]);
        end
        OP_SPHERE: begin
          lo_d[a] = EW'(pos[a]);
          hi_d[a] = EW'(pos[a]);
        end
        OP_CUBE: begin
          lo_d[a] = EW'(pos[a]) - rad_ext;
          hi_d[a] = EW'(pos[a]) + rad_ext;
        end
        default: begin
          lo_d[a] = EW'(pos[a]);
          hi_d[a] = EW'(ext[a]);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) begin
      op1_q  <= req_i.op;
      rad1_q <= req_i.radius;
      for (int a = 0; a < 3; a++) begin
        lo1_q[a] <= lo_d[a];
        hi1_q[a] <= hi_d[a];
      end
    end
  end

  // Stage 2: every normal component times both corner coordinates.
  logic signed [PW-1:0] plo2_q [NUM_PLANES][3];
  logic signed [PW-1:0] phi2_q [NUM_PLANES][3];
  op_t                  op2_q;
  logic [RW-1:0]        rad2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      op2_q  <= op1_q;
      rad2_q <= rad1_q;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int a = 0; a < 3; a++) begin
          plo2_q[p][a] <= PW'(nrm[p][a]) * PW'(lo1_q[a]);
          phi2_q[p][a] <= PW'(nrm[p][a]) * PW'(hi1_q[a]);
        end
      end
    end
  end

  // Stage 3: per plane, the largest and smallest corner distance (the axes are
  // independent, so each picks its larger or smaller product) and twice the
  // center distance, all in units of 2^-14.
  logic signed [SW-1:0] mx_d [NUM_PLANES];
  logic signed [SW-1:0] mn_d [NUM_PLANES];
  logic signed [CW-1:0] c2_d [NUM_PLANES];
  logic signed [SW-1:0] mx3_q [NUM_PLANES];
  logic signed [SW-1:0] mn3_q [NUM_PLANES];
  logic signed [CW-1:0] c23_q [NUM_PLANES];
  op_t                  op3_q;
  logic [RW-1:0]        rad3_q;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      mx_d[p] = SW'(plane_q[p].d) <<< Q_SHIFT;
      mn_d[p] = SW'(plane_q[p].d) <<< Q_SHIFT;
      c2_d[p] = CW'(plane_q[p].d) <<< (Q_SHIFT + 1);
      for (int a = 0; a < 3; a++) begin
        if (plo2_q[p][a] > phi2_q[p][a]) begin
          mx_d[p] = mx_d[p] + SW'(plo2_q[p][a]);
          mn_d[p] = mn_d[p] + SW'(phi2_q[p][a]);
        end else begin
          mx_d[p] = mx_d[p] + SW'(phi2_q[p][a]);
          mn_d[p] = mn_d[p] + SW'(plo2_q[p][a]);
        end
        c2_d[p] = c2_d[p] + CW'(plo2_q[p][a]) + CW'(phi2_q[p][a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      op3_q  <= op2_q;
      rad3_q <= rad2_q;
      for (int p = 0; p < NUM_PLANES; p++) begin
        mx3_q[p] <= mx_d[p];
        mn3_q[p] <= mn_d[p];
        c23_q[p] <= c2_d[p];
      end
    end
  end

  // Stage 4: compare against zero and the doubled radius, combine the planes.
  logic signed [CW-1:0] rq2;
  logic signed [CW-1:0] rq2_neg;
  logic                 ctr_lt;
  logic                 ctr_le;
  logic                 ctr_ge_all;
  logic                 box_out;
  logic                 box_full;
  verdict_t             verdict_d;
  verdict_t             verdict_q;

  always_comb begin
    rq2        = CW'({rad3_q, {(Q_SHIFT + 1){1'b0}}});
    rq2_neg    = -rq2;
    ctr_lt     = 1'b0;
    ctr_le     = 1'b0;
    ctr_ge_all = 1'b1;
    box_out    = 1'b0;
    box_full   = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      ctr_lt     = ctr_lt     | (c23_q[p] <  rq2_neg);
      ctr_le     = ctr_le     | (c23_q[p] <= rq2_neg);
      ctr_ge_all = ctr_ge_all & (c23_q[p] >= rq2);
      box_out    = box_out    | (mx3_q[p] <= SW'(0));
      box_full   = box_full   & (mn3_q[p] >  SW'(0));
    end
    case (op3_q)
      OP_BOUNDS: verdict_d = (ctr_lt || box_out) ? VERDICT_OUTSIDE : VERDICT_PARTIAL;
      OP_SPHERE: begin
        if (ctr_le)          verdict_d = VERDICT_OUTSIDE;
        else if (ctr_ge_all) verdict_d = VERDICT_INSIDE;
        else                 verdict_d = VERDICT_PARTIAL;
      end
      OP_CUBE: begin
        if (box_out)         verdict_d = VERDICT_OUTSIDE;
        else if (box_full)   verdict_d = VERDICT_INSIDE;
        else                 verdict_d = VERDICT_PARTIAL;
      end
      default:   verdict_d = box_out ? VERDICT_OUTSIDE : VERDICT_PARTIAL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign rsp_o.valid   = v4_q;
  assign rsp_o.verdict = verdict_q;

endmodule
